[rtl/core/c3dc_pkg.sv]
// Package for the 3x3 convolution block: widths, codes, constants and the
// structs shared by the front, the queue, the back end and the top level.
// No dependencies.
package c3dc_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int COEF_BITS_DEF = 8;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 16;
  localparam int COL_W      = 10;
  localparam int MASK_W     = 24;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int MIN_DIM   = 3;
  localparam int WIN_TAPS  = 9;
  localparam int ROW_TAPS  = 3;
  localparam int WIN_COLS  = 6;

  // queue between front and back; depth must be a power of two
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // divide by nine through a reciprocal, valid for 0 .. CLAMP_LIMIT-1
  localparam int DIV9_RECIP  = 7282;
  localparam int DIV9_SHIFT  = 16;
  localparam int DIV_IN_W    = 12;
  localparam int RECIP_W     = 13;
  localparam int PIX_MAX     = 255;
  localparam int CLAMP_LIMIT = 9 * (PIX_MAX + 1);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MASK_TOP    = 3'd0;
  localparam cfg_idx_t CFG_MASK_MIDDLE = 3'd1;
  localparam cfg_idx_t CFG_MASK_BOTTOM = 3'd2;
  localparam cfg_idx_t CFG_IMG_WIDTH   = 3'd3;
  localparam cfg_idx_t CFG_IMG_HEIGHT  = 3'd4;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 16'd480;

  typedef struct packed {
    logic [MASK_W-1:0]  mask_top;
    logic [MASK_W-1:0]  mask_middle;
    logic [MASK_W-1:0]  mask_bottom;
    logic [IMG_W_W-1:0] width;
    logic [IMG_H_W-1:0] height;
  } c3dc_cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } c3dc_meta_t;

  // taps: top row left..right, middle row, bottom row
  typedef struct packed {
    logic [WIN_TAPS-1:0][PIX_W-1:0] pix;
    c3dc_meta_t                     meta;
  } c3dc_win_t;

  typedef struct packed {
    logic      valid;
    c3dc_win_t data;
  } c3dc_push_t;

endpackage

[rtl/core/c3dc_if.sv]
// Stream interfaces for the pixel input channel and the result channel.
// Depends on c3dc_pkg.
interface c3dc_pix_if import c3dc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface c3dc_res_if import c3dc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] filtered_value;
  logic [ROW_W-1:0] centre_row;
  logic [COL_W-1:0] centre_col;
  logic             frame_last;

  modport source (output valid, output filtered_value, output centre_row,
                  output centre_col, output frame_last, input ready);
  modport sink   (input valid, input filtered_value, input centre_row,
                  input centre_col, input frame_last, output ready);
endinterface

[rtl/core/c3dc_front.sv]
// Front end: row/column counters, the two line stores (one 16-bit memory)
// and the 3x3 window; pushes complete interior windows into the queue.
// Depends on c3dc_pkg and c3dc_pix_if.
module c3dc_front import c3dc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  c3dc_pix_if.sink           in_ch,
  input  c3dc_cfg_t          cfg,
  input  logic [Q_CNT_W-1:0] q_cnt,
  output c3dc_push_t         push
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > IMG_W_W) ? WW : IMG_W_W;

  logic [EW-1:0]    w_in;
  logic [EW-1:0]    w_eff;
  logic [CW-1:0]    w_last;
  logic [ROW_W-1:0] h_eff;
  logic [ROW_W-1:0] h_last;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    c0, c1, cur_c, cm1;
  logic [ROW_W-1:0] r0, r1, cur_r;
  logic             accept;
  logic             prod;
  logic             last;
  logic [Q_CNT_W:0] credit;

  logic [2*PIX_W-1:0] ls_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] ls_rd_r;
  logic [2*PIX_W-1:0] ls_cur;
  logic [2*PIX_W-1:0] ls_wdata;
  logic [2*PIX_W-1:0] fwd_d_r;
  logic               fwd_v_r, fwd_v_nxt;

  logic               s1_v_r;
  logic               s1_prod_r;
  logic [CW-1:0]      s1_c_r;
  logic [PIX_W-1:0]   s1_px_r;
  c3dc_meta_t         s1_meta_r;
  logic [PIX_W-1:0]   top_px, mid_px;
  logic [PIX_W-1:0]   win_r [WIN_COLS];

  // effective frame size
  always_comb begin
    w_in = EW'(cfg.width);
    if (w_in < EW'(MIN_DIM)) begin
      w_eff = EW'(MIN_DIM);
    end else if (w_in > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_in;
    end
    w_last = CW'(w_eff - EW'(1));
    h_eff  = (cfg.height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : cfg.height;
    h_last = h_eff - ROW_W'(1);
  end

  // position of the incoming pixel; a counter past a shrunk size wraps first
  always_comb begin
    c0 = in_ch.frame_start ? '0 : col_r;
    r0 = in_ch.frame_start ? '0 : row_r;
    c1 = c0;
    r1 = r0;
    if (c0 > w_last) begin
      c1 = '0;
      r1 = r0 + ROW_W'(1);
    end
    cur_c = c1;
    cur_r = (r1 > h_last) ? '0 : r1;
    if (cur_c >= w_last) begin
      col_nxt = '0;
      row_nxt = (cur_r >= h_last) ? '0 : cur_r + ROW_W'(1);
    end else begin
      col_nxt = cur_c + CW'(1);
      row_nxt = cur_r;
    end
    cm1  = cur_c - CW'(1);
    prod = (cur_r >= ROW_W'(2)) && (cur_c >= CW'(2));
    last = (cur_r == h_last) && (cur_c == w_last);
  end

  // credit: room for whatever is still on its way into the queue
  assign credit      = {1'b0, q_cnt} + {{Q_CNT_W{1'b0}}, s1_v_r & s1_prod_r};
  assign in_ch.ready = credit < (Q_CNT_W + 1)'(Q_DEPTH);
  assign accept      = in_ch.valid && in_ch.ready;

  // line stores: {older, newer}; read at accept, written in the following cycle
  assign ls_cur   = fwd_v_r ? fwd_d_r : ls_rd_r;
  assign top_px   = ls_cur[2*PIX_W-1:PIX_W];
  assign mid_px   = ls_cur[PIX_W-1:0];
  assign ls_wdata = {mid_px, s1_px_r};
  assign fwd_v_nxt = s1_v_r && accept && (s1_c_r == cur_c);

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      ls_mem[s1_c_r] <= ls_wdata;
    end
    ls_rd_r <= ls_mem[cur_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_v_r    <= 1'b0;
      s1_prod_r <= 1'b0;
      fwd_v_r   <= 1'b0;
      for (int i = 0; i < WIN_COLS; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s1_v_r  <= accept;
      fwd_v_r <= fwd_v_nxt;
      if (accept) begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        s1_prod_r <= prod;
      end
      if (s1_v_r) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= top_px;
        win_r[4] <= mid_px;
        win_r[5] <= s1_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_d_r <= ls_wdata;
    if (accept) begin
      s1_c_r         <= cur_c;
      s1_px_r        <= in_ch.pixel;
      s1_meta_r.row  <= cur_r - ROW_W'(1);
      s1_meta_r.col  <= COL_W'(cm1);
      s1_meta_r.last <= last;
    end
  end

  always_comb begin
    push.valid       = s1_v_r && s1_prod_r;
    push.data.pix[0] = win_r[0];
    push.data.pix[1] = win_r[3];
    push.data.pix[2] = top_px;
    push.data.pix[3] = win_r[1];
    push.data.pix[4] = win_r[4];
    push.data.pix[5] = mid_px;
    push.data.pix[6] = win_r[2];
    push.data.pix[7] = win_r[5];
    push.data.pix[8] = s1_px_r;
    push.data.meta   = s1_meta_r;
  end

endmodule

[rtl/core/c3dc_queue.sv]
// Small window queue that decouples the front end from the MAC back end.
// Depends on c3dc_pkg.
module c3dc_queue import c3dc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  c3dc_push_t         push,
  input  logic               pop,
  output logic               pop_valid,
  output c3dc_win_t          pop_data,
  output logic [Q_CNT_W-1:0] cnt
);

  c3dc_win_t          q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  // front never pushes into a full queue (credit check on its side)
  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_mem[wr_ptr_r] <= push.data;
    end
  end

  assign pop_valid = cnt_r != '0;
  assign pop_data  = q_mem[rd_ptr_r];
  assign cnt       = cnt_r;

endmodule

[rtl/core/c3dc_back.sv]
// Back end: nine products, row sums, window sum, divide by nine and clamp,
// as a stallable pipeline ending in the output register.
// Depends on c3dc_pkg and c3dc_res_if.
module c3dc_back import c3dc_pkg::*; #(
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  c3dc_cfg_t  cfg,
  input  logic       q_valid,
  input  c3dc_win_t  q_data,
  output logic       q_pop,
  c3dc_res_if.source out_ch
);

  localparam int PW   = COEF_BITS + PIX_W + 1;
  localparam int RW   = PW + 2;
  localparam int SW   = PW + 4;
  localparam int MW   = (3 * COEF_BITS > MASK_W) ? 3 * COEF_BITS : MASK_W;
  localparam int DP_W = DIV_IN_W + RECIP_W;

  logic [MW-1:0]               mrow [ROW_TAPS];
  logic signed [COEF_BITS-1:0] coef [WIN_TAPS];
  logic signed [PW-1:0]        prod_c [WIN_TAPS];
  logic signed [RW-1:0]        rs_c [ROW_TAPS];
  logic signed [SW-1:0]        sum_c;

  logic                 v1_r, v2_r, v3_r, ov_r;
  logic                 adv1, adv2, adv3, adv_o;
  logic signed [PW-1:0] p1_prod_r [WIN_TAPS];
  logic signed [RW-1:0] p2_rs_r [ROW_TAPS];
  logic signed [SW-1:0] p3_sum_r;
  c3dc_meta_t           p1_meta_r, p2_meta_r, p3_meta_r, o_meta_r;
  logic [PIX_W-1:0]     o_val_r;

  logic                 s_neg, s_big;
  logic [DIV_IN_W-1:0]  dq;
  logic [DP_W-1:0]      dprod;
  logic [PIX_W-1:0]     fv;

  assign mrow[0] = MW'(cfg.mask_top);
  assign mrow[1] = MW'(cfg.mask_middle);
  assign mrow[2] = MW'(cfg.mask_bottom);

  always_comb begin
    for (int j = 0; j < ROW_TAPS; j++) begin
      for (int i = 0; i < ROW_TAPS; i++) begin
        coef[j*ROW_TAPS+i] = $signed(mrow[j][i*COEF_BITS +: COEF_BITS]);
      end
    end
    for (int k = 0; k < WIN_TAPS; k++) begin
      prod_c[k] = PW'(coef[k]) * PW'($signed({1'b0, q_data.pix[k]}));
    end
    for (int j = 0; j < ROW_TAPS; j++) begin
      rs_c[j] = RW'(p1_prod_r[j*ROW_TAPS]) + RW'(p1_prod_r[j*ROW_TAPS+1])
              + RW'(p1_prod_r[j*ROW_TAPS+2]);
    end
    sum_c = SW'(p2_rs_r[0]) + SW'(p2_rs_r[1]) + SW'(p2_rs_r[2]);
  end

  // truncating divide only matters below the clamp limit
  always_comb begin
    s_neg = p3_sum_r[SW-1];
    s_big = !s_neg && (p3_sum_r > SW'(CLAMP_LIMIT - 1));
    dq    = p3_sum_r[DIV_IN_W-1:0];
    dprod = DP_W'(dq) * DP_W'(DIV9_RECIP);
    if (s_neg) begin
      fv = '0;
    end else if (s_big) begin
      fv = PIX_W'(PIX_MAX);
    end else begin
      fv = dprod[DIV9_SHIFT +: PIX_W];
    end
  end

  assign adv_o = !ov_r || out_ch.ready;
  assign adv3  = !v3_r || adv_o;
  assign adv2  = !v2_r || adv3;
  assign adv1  = !v1_r || adv2;
  assign q_pop = q_valid && adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= q_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv_o) begin
        ov_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int k = 0; k < WIN_TAPS; k++) begin
        p1_prod_r[k] <= prod_c[k];
      end
      p1_meta_r <= q_data.meta;
    end
    if (adv2) begin
      for (int j = 0; j < ROW_TAPS; j++) begin
        p2_rs_r[j] <= rs_c[j];
      end
      p2_meta_r <= p1_meta_r;
    end
    if (adv3) begin
      p3_sum_r  <= sum_c;
      p3_meta_r <= p2_meta_r;
    end
    if (adv_o) begin
      o_val_r  <= fv;
      o_meta_r <= p3_meta_r;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.filtered_value = o_val_r;
  assign out_ch.centre_row     = o_meta_r.row;
  assign out_ch.centre_col     = o_meta_r.col;
  assign out_ch.frame_last     = o_meta_r.last;

endmodule

[rtl/core/conv3x3_div9_clamp_top.sv]
// 3x3 convolution, divide by nine, clamp: sustained rate one pixel per cycle while
// the result channel does not stall, set by the line-store memory doing one read
// and one write per cycle.
// Border pixels give no result. Synchronous active-low reset clears counters,
// window, queue and pipeline valids and loads the registers with 0,0,0,640,480.
module conv3x3_div9_clamp_top import c3dc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  c3dc_pix_if.sink              in_ch,
  c3dc_res_if.source            out_ch,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  c3dc_cfg_t          cfg_r;
  c3dc_push_t         push;
  logic               q_pop;
  logic               q_valid;
  c3dc_win_t          q_data;
  logic [Q_CNT_W-1:0] q_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mask_top    <= '0;
      cfg_r.mask_middle <= '0;
      cfg_r.mask_bottom <= '0;
      cfg_r.width       <= IMG_W_RST;
      cfg_r.height      <= IMG_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MASK_TOP:    cfg_r.mask_top    <= cfg_data;
        CFG_MASK_MIDDLE: cfg_r.mask_middle <= cfg_data;
        CFG_MASK_BOTTOM: cfg_r.mask_bottom <= cfg_data;
        CFG_IMG_WIDTH:   cfg_r.width       <= cfg_data[IMG_W_W-1:0];
        CFG_IMG_HEIGHT:  cfg_r.height      <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  c3dc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg_r),
    .q_cnt (q_cnt),
    .push  (push)
  );

  c3dc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .cnt       (q_cnt)
  );

  c3dc_back #(.COEF_BITS(COEF_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[rtl/core/c3dc_checker.sv]
// Port-level checker for the convolution top level, attached by bind.
// Depends on c3dc_pkg and conv3x3_div9_clamp_top.
module c3dc_checker import c3dc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_filtered_value,
  input logic [ROW_W-1:0] out_centre_row,
  input logic [COL_W-1:0] out_centre_col,
  input logic             out_frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_filtered_value) && $stable(out_centre_row)
      && $stable(out_centre_col) && $stable(out_frame_last))
    else $error("result payload changed while stalled");

  // after reset the pipeline is empty and the queue has room
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty and ready after reset");

  // results are only given for interior pixels
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_centre_row != '0 && out_centre_col != '0)
    else $error("result for a border pixel");

endmodule

bind conv3x3_div9_clamp_top c3dc_checker u_c3dc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_filtered_value (out_ch.filtered_value),
  .out_centre_row     (out_ch.centre_row),
  .out_centre_col     (out_ch.centre_col),
  .out_frame_last     (out_ch.frame_last)
);
